// ===== hdl/uirb_pkg.sv =====
`timescale 1ns / 1ps

package uirb_pkg;

    localparam int DATA_W = 8;
    localparam int ACT_W  = 2;

    localparam int DEF_RX_DEPTH = 64;
    localparam int DEF_TX_DEPTH = 64;

    localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EVENT = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== hdl/uart_irq_ring_buffers.sv =====
`timescale 1ns / 1ps

// UART ring buffer engine with a receive ring and a transmit ring. Pulse start
// while busy is low to hand in one item (put, get or UART status event); each
// item is handled in two steps, one to read both ring heads from their memories
// and one to update the rings, so busy stays high during the update step after accept.
// Exactly one result appears on the o_ result ports for a single cycle, marked
// by o_strobe, in the cycle in which busy drops; the receiver cannot stall it
// and must capture it then. A new item may be started in the same cycle that the
// previous result is shown. The receive enable register is written through the
// cfg channel, which is always ready and is meant to be used while idle.
module uart_irq_ring_buffers #(
    parameter int RX_DEPTH = uirb_pkg::DEF_RX_DEPTH,
    parameter int TX_DEPTH = uirb_pkg::DEF_TX_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [uirb_pkg::ACT_W-1:0]  i_action,
    input  logic [uirb_pkg::DATA_W-1:0] i_data_byte,
    input  logic                        i_tx_empty_flag,
    input  logic                        i_rx_full_flag,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_done_res,
    output logic [uirb_pkg::DATA_W-1:0] o_read_byte,
    output logic                        o_uart_write,
    output logic [uirb_pkg::DATA_W-1:0] o_uart_byte,
    output logic                        o_rx_dropped,
    output logic                        o_tx_irq_on
);
    import uirb_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    uirb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (cmd),
        .o_strobe (o_strobe)
    );

    uirb_dp #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_tx_empty_flag (i_tx_empty_flag),
        .i_rx_full_flag  (i_rx_full_flag),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_done_res      (o_done_res),
        .o_read_byte     (o_read_byte),
        .o_uart_write    (o_uart_write),
        .o_uart_byte     (o_uart_byte),
        .o_rx_dropped    (o_rx_dropped),
        .o_tx_irq_on     (o_tx_irq_on)
    );

endmodule

// ===== hdl/uirb_ctrl.sv =====
`timescale 1ns / 1ps

module uirb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output uirb_pkg::t_dp_cmd o_cmd,
    output logic             o_strobe
);
    import uirb_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd n_cmd;
    logic    r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_cmd.exec;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_cmd    = n_cmd;
    assign o_strobe = r_strobe;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ST_EXEC))
        else $error("accepted item did not move to execution");
    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_strobe && r_state == ST_IDLE))
        else $error("execution did not produce exactly one result");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result strobe while busy");
`endif

endmodule

// ===== hdl/uirb_dp.sv =====
`timescale 1ns / 1ps

module uirb_dp #(
    parameter int RX_DEPTH = uirb_pkg::DEF_RX_DEPTH,
    parameter int TX_DEPTH = uirb_pkg::DEF_TX_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  uirb_pkg::t_dp_cmd             i_cmd,
    input  logic [uirb_pkg::ACT_W-1:0]    i_action,
    input  logic [uirb_pkg::DATA_W-1:0]   i_data_byte,
    input  logic                          i_tx_empty_flag,
    input  logic                          i_rx_full_flag,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    output logic                          o_done_res,
    output logic [uirb_pkg::DATA_W-1:0]   o_read_byte,
    output logic                          o_uart_write,
    output logic [uirb_pkg::DATA_W-1:0]   o_uart_byte,
    output logic                          o_rx_dropped,
    output logic                          o_tx_irq_on
);
    import uirb_pkg::*;

    localparam int RX_PW = $clog2(RX_DEPTH);
    localparam int TX_PW = $clog2(TX_DEPTH);
    localparam int RX_FW = $clog2(RX_DEPTH + 1);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);

    localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);
    localparam logic [RX_FW-1:0] RX_FULL = RX_FW'(RX_DEPTH);
    localparam logic [TX_FW-1:0] TX_FULL = TX_FW'(TX_DEPTH);

    logic [DATA_W-1:0] rx_mem [RX_DEPTH];
    logic [DATA_W-1:0] tx_mem [TX_DEPTH];

    logic [DATA_W-1:0] r_rx_q;
    logic [DATA_W-1:0] r_tx_q;

    logic [RX_PW-1:0] r_rx_head, r_rx_tail, n_rx_head, n_rx_tail;
    logic [TX_PW-1:0] r_tx_head, r_tx_tail, n_tx_head, n_tx_tail;
    logic [RX_FW-1:0] r_rx_fill, n_rx_fill;
    logic [TX_FW-1:0] r_tx_fill, n_tx_fill;
    logic             r_tx_en, n_tx_en;
    logic             r_rx_en;

    logic [ACT_W-1:0]  r_action;
    logic [DATA_W-1:0] r_byte;
    logic              r_tx_empty;
    logic              r_rx_full;

    logic              n_done, n_uart_write, n_dropped;
    logic [DATA_W-1:0] n_read_byte, n_uart_byte;
    logic              rx_we, tx_we;

    logic              r_done, r_uart_write, r_dropped, r_tx_irq_on;
    logic [DATA_W-1:0] r_read_byte, r_uart_byte;

    // Both rings are read at their head every cycle; the data captured at
    // the accept edge is what the following execution cycle consumes.
    always_ff @(posedge i_clk) begin
        r_rx_q <= rx_mem[r_rx_head];
        r_tx_q <= tx_mem[r_tx_head];
        if (rx_we) begin
            rx_mem[r_rx_tail] <= r_byte;
        end
        if (tx_we) begin
            tx_mem[r_tx_tail] <= r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= i_action;
            r_byte     <= i_data_byte;
            r_tx_empty <= i_tx_empty_flag;
            r_rx_full  <= i_rx_full_flag;
        end
        if (i_cmd.exec) begin
            r_done      <= n_done;
            r_read_byte <= n_read_byte;
            r_uart_write <= n_uart_write;
            r_uart_byte <= n_uart_byte;
            r_dropped   <= n_dropped;
            r_tx_irq_on <= n_tx_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_rx_fill <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_tx_fill <= '0;
            r_tx_en   <= 1'b0;
            r_rx_en   <= 1'b1;
        end else begin
            if (i_cmd.exec) begin
                r_rx_head <= n_rx_head;
                r_rx_tail <= n_rx_tail;
                r_rx_fill <= n_rx_fill;
                r_tx_head <= n_tx_head;
                r_tx_tail <= n_tx_tail;
                r_tx_fill <= n_tx_fill;
                r_tx_en   <= n_tx_en;
            end
            if (i_cfg_we) begin
                r_rx_en <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_rx_fill    = r_rx_fill;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_tx_fill    = r_tx_fill;
        n_tx_en      = r_tx_en;
        n_done       = 1'b0;
        n_read_byte  = '0;
        n_uart_write = 1'b0;
        n_uart_byte  = '0;
        n_dropped    = 1'b0;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        case (r_action)
            ACT_PUT: begin
                if (r_tx_fill != TX_FULL) begin
                    tx_we     = i_cmd.exec;
                    n_tx_tail = (r_tx_tail == TX_LAST) ? '0 : r_tx_tail + 1'b1;
                    n_tx_fill = r_tx_fill + 1'b1;
                    n_tx_en   = 1'b1;
                    n_done    = 1'b1;
                end
            end
            ACT_GET: begin
                if (r_rx_fill != '0) begin
                    n_read_byte = r_rx_q;
                    n_rx_head   = (r_rx_head == RX_LAST) ? '0 : r_rx_head + 1'b1;
                    n_rx_fill   = r_rx_fill - 1'b1;
                    n_done      = 1'b1;
                end
            end
            ACT_EVENT: begin
                if (r_tx_en && r_tx_empty) begin
                    if (r_tx_fill != '0) begin
                        n_uart_byte  = r_tx_q;
                        n_uart_write = 1'b1;
                        n_tx_head    = (r_tx_head == TX_LAST) ? '0 : r_tx_head + 1'b1;
                        n_tx_fill    = r_tx_fill - 1'b1;
                    end
                    // The enable drops as soon as the ring has drained.
                    if (n_tx_fill == '0) begin
                        n_tx_en = 1'b0;
                    end
                end
                if (r_rx_en && r_rx_full) begin
                    if (r_rx_fill != RX_FULL) begin
                        rx_we     = i_cmd.exec;
                        n_rx_tail = (r_rx_tail == RX_LAST) ? '0 : r_rx_tail + 1'b1;
                        n_rx_fill = r_rx_fill + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done_res   = r_done;
    assign o_read_byte  = r_read_byte;
    assign o_uart_write = r_uart_write;
    assign o_uart_byte  = r_uart_byte;
    assign o_rx_dropped = r_dropped;
    assign o_tx_irq_on  = r_tx_irq_on;

`ifndef SYNTHESIS
    a_rx_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_fill <= RX_FULL)
        else $error("receive fill count beyond ring depth");
    a_tx_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_fill <= TX_FULL)
        else $error("transmit fill count beyond ring depth");
    a_tx_en_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_en |-> (r_tx_fill != '0))
        else $error("transmit interrupt enabled with an empty ring");
    a_drop_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_dropped) |-> (r_rx_fill == RX_FULL && !rx_we))
        else $error("received byte dropped while ring had room");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import uirb_pkg::*;

    localparam int RXD = DEF_RX_DEPTH;
    localparam int TXD = DEF_TX_DEPTH;
    localparam int RX_AW = $clog2(RXD);
    localparam int TX_AW = $clog2(TXD);
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rd_byte;
        logic              wr;
        logic [DATA_W-1:0] wr_byte;
        logic              dropped;
        logic              tx_ie;
    } t_ring_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [ACT_W-1:0]  i_action;
    logic [DATA_W-1:0] i_data_byte;
    logic              i_tx_empty_flag;
    logic              i_rx_full_flag;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_data;
    logic              o_strobe;
    logic              o_done_res;
    logic [DATA_W-1:0] o_read_byte;
    logic              o_uart_write;
    logic [DATA_W-1:0] o_uart_byte;
    logic              o_rx_dropped;
    logic              o_tx_irq_on;

    // Shadow copy of both rings and the interrupt enables.
    logic [DATA_W-1:0] rx_ring [RXD];
    logic [DATA_W-1:0] tx_ring [TXD];
    logic [RX_AW-1:0]  rx_rd, rx_wr;
    logic [RX_AW:0]    rx_count;
    logic [TX_AW-1:0]  tx_rd, tx_wr;
    logic [TX_AW:0]    tx_count;
    logic              tx_ie;
    logic              rx_ie;

    t_ring_result expected_q[$];
    int           pending;
    int           errors;
    int           cycle_count;
    bit           gaps_on;

    uart_irq_ring_buffers dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_tx_empty_flag (i_tx_empty_flag),
        .i_rx_full_flag  (i_rx_full_flag),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_done_res      (o_done_res),
        .o_read_byte     (o_read_byte),
        .o_uart_write    (o_uart_write),
        .o_uart_byte     (o_uart_byte),
        .o_rx_dropped    (o_rx_dropped),
        .o_tx_irq_on     (o_tx_irq_on)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_ring_result apply_item(input logic [ACT_W-1:0] act,
                                                input logic [DATA_W-1:0] data,
                                                input logic txe, input logic rxf);
        t_ring_result r;
        r = '0;
        case (act)
            ACT_PUT: begin
                if (tx_count < TXD) begin
                    tx_ring[tx_wr] = data;
                    tx_wr = (tx_wr == TXD - 1) ? '0 : tx_wr + 1'b1;
                    tx_count++;
                    tx_ie = 1'b1;
                    r.done = 1'b1;
                end
            end
            ACT_GET: begin
                if (rx_count > 0) begin
                    r.rd_byte = rx_ring[rx_rd];
                    rx_rd = (rx_rd == RXD - 1) ? '0 : rx_rd + 1'b1;
                    rx_count--;
                    r.done = 1'b1;
                end
            end
            ACT_EVENT: begin
                // Transmit side is served before the receive side.
                if (tx_ie && txe) begin
                    if (tx_count > 0) begin
                        r.wr_byte = tx_ring[tx_rd];
                        tx_rd = (tx_rd == TXD - 1) ? '0 : tx_rd + 1'b1;
                        tx_count--;
                        r.wr = 1'b1;
                    end
                    if (tx_count == 0) tx_ie = 1'b0;
                end
                if (rx_ie && rxf) begin
                    if (rx_count < RXD) begin
                        rx_ring[rx_wr] = data;
                        rx_wr = (rx_wr == RXD - 1) ? '0 : rx_wr + 1'b1;
                        rx_count++;
                    end else begin
                        r.dropped = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.tx_ie = tx_ie;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_ring_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    pending--;
                    check_field("done_res", int'(want.done), int'(o_done_res));
                    check_field("read_byte", int'(want.rd_byte), int'(o_read_byte));
                    check_field("uart_write", int'(want.wr), int'(o_uart_write));
                    check_field("uart_byte", int'(want.wr_byte), int'(o_uart_byte));
                    check_field("rx_dropped", int'(want.dropped), int'(o_rx_dropped));
                    check_field("tx_irq_on", int'(want.tx_ie), int'(o_tx_irq_on));
                end
            end
            if (start && !busy) begin
                expected_q.push_back(apply_item(i_action, i_data_byte,
                                                i_tx_empty_flag, i_rx_full_flag));
                pending++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                             input logic txe, input logic rxf);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_action        <= act;
        i_data_byte     <= data;
        i_tx_empty_flag <= txe;
        i_rx_full_flag  <= rxf;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and let every outstanding item come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_rx_enable(input logic value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        rx_ie = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_ops();
        send_item(ACT_GET, 8'h00, 1'b1, 1'b1);
        send_item(ACT_EVENT, 8'h3C, 1'b1, 1'b0);
        send_item(ACT_PUT, 8'h00, 1'b0, 1'b0);
        send_item(ACT_PUT, 8'hFF, 1'b1, 1'b1);
        send_item(ACT_EVENT, 8'h11, 1'b0, 1'b0);
        send_item(ACT_EVENT, 8'hFF, 1'b1, 1'b1);
        send_item(ACT_EVENT, 8'h00, 1'b1, 1'b1);
        send_item(ACT_EVENT, 8'h80, 1'b1, 1'b0);
        send_item(ACT_GET, 8'hFF, 1'b0, 1'b0);
        send_item(ACT_GET, 8'h00, 1'b0, 1'b0);
        send_item(ACT_GET, 8'h00, 1'b0, 1'b0);
        send_item(ACT_UNUSED, 8'hA5, 1'b1, 1'b1);
        send_item(ACT_UNUSED, 8'h5A, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_rx_disabled();
        set_rx_enable(1'b0);
        send_item(ACT_EVENT, 8'h5A, 1'b0, 1'b1);
        send_item(ACT_PUT, 8'h12, 1'b0, 1'b0);
        send_item(ACT_EVENT, 8'hC3, 1'b1, 1'b1);
        send_item(ACT_GET, 8'h00, 1'b0, 1'b0);
        set_rx_enable(1'b1);
    endtask

    // Fill both rings to the brim, overflow each one, then empty them again.
    task automatic test_full_rings();
        repeat (TXD + 1) send_item(ACT_PUT, DATA_W'($urandom_range(0, 255)), 1'b0, 1'b0);
        repeat (RXD + 1) send_item(ACT_EVENT, DATA_W'($urandom_range(0, 255)), 1'b1, 1'b1);
        repeat (RXD + 1) send_item(ACT_GET, DATA_W'($urandom_range(0, 255)), 1'b1, 1'b0);
        drain();
    endtask

    task automatic random_phase(input int count, input int put_w, input int get_w,
                                input int evt_w);
        int sel;
        logic [ACT_W-1:0] act;
        repeat (count) begin
            sel = $urandom_range(0, put_w + get_w + evt_w);
            if (sel < put_w) act = ACT_PUT;
            else if (sel < put_w + get_w) act = ACT_GET;
            else if (sel < put_w + get_w + evt_w) act = ACT_EVENT;
            else act = ACT_UNUSED;
            send_item(act, DATA_W'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                      $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_random_traffic();
        gaps_on = 1'b1;
        random_phase(80, 3, 3, 4);
        set_rx_enable(1'b0);
        gaps_on = 1'b0;
        random_phase(70, 6, 1, 3);
        set_rx_enable(1'b1);
        gaps_on = 1'b1;
        random_phase(80, 1, 1, 7);
        set_rx_enable(1'b0);
        random_phase(30, 2, 4, 3);
        set_rx_enable(1'b1);
        random_phase(78, 1, 6, 3);
        drain();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_action        <= ACT_PUT;
        i_data_byte     <= '0;
        i_tx_empty_flag <= 1'b0;
        i_rx_full_flag  <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= 1'b0;
        pending     = 0;
        errors      = 0;
        cycle_count = 0;
        gaps_on     = 1'b1;
        for (int k = 0; k < RXD; k++) rx_ring[k] = '0;
        for (int k = 0; k < TXD; k++) tx_ring[k] = '0;
        rx_rd    = '0;
        rx_wr    = '0;
        rx_count = '0;
        tx_rd    = '0;
        tx_wr    = '0;
        tx_count = '0;
        tx_ie    = 1'b0;
        rx_ie    = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_rx_disabled();
        test_full_rings();
        test_random_traffic();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
